[rtl/hashed_key_ttl_cache_defines.svh]
// assertion macros used by the cache controller
`ifndef HASHED_KEY_TTL_CACHE_DEFINES_SVH
`define HASHED_KEY_TTL_CACHE_DEFINES_SVH
`ifndef SYNTH
// checked property, quiet while reset is high
`define HKTC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("hktc assertion failed");
// checked property, also active during reset
`define HKTC_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("hktc assertion failed");
`else
`define HKTC_ASSERT(label, clk, rst, prop)
`define HKTC_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

[rtl/hktc_pkg.sv]
package hktc_pkg;

  // field widths
  localparam int HASH_W  = 64;
  localparam int BYTE_W  = 8;
  localparam int WORD_W  = 32;
  localparam int OP_W    = 2;
  localparam int CFG_IDX_W = 8;

  // operation codes
  localparam logic [OP_W-1:0] OP_HASH   = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_STORE  = 2'd2;

  // result kinds
  localparam logic RESULT_HASH   = 1'b0;
  localparam logic RESULT_LOOKUP = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CACHE_ENABLE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TTL_SECONDS  = 8'd1;

  // reset values and fixed words
  localparam logic [HASH_W-1:0] FNV_BASIS   = 64'hcbf2_9ce4_8422_2325;
  localparam logic [WORD_W-1:0] MISS_SCORE  = 32'hBF80_0000;
  localparam logic [WORD_W-1:0] TTL_RESET   = 32'd3600;

  // bits consumed per cycle by the slot remainder unit
  localparam int MOD_BITS = 4;

  // one table entry
  typedef struct packed {
    logic              valid;
    logic [HASH_W-1:0] tag;
    logic [WORD_W-1:0] sigma;
    logic [WORD_W-1:0] stamp;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic mod_start;
    logic hash_step;
    logic mem_read;
    logic mem_write;
    logic check;
    logic clear_step;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic mod_done;
    logic clear_last;
  } status_t;

  // fnv-1a step: xor the byte, multiply by 2^40 + 0x1b3 modulo 2^64
  function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                 input logic [BYTE_W-1:0] b);
    logic [HASH_W-1:0] x;
    x = h ^ {{(HASH_W-BYTE_W){1'b0}}, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

[rtl/hktc_mod.sv]
module hktc_mod #(
  parameter int ENTRIES = 256,
  localparam int IW = $clog2(ENTRIES)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [hktc_pkg::HASH_W-1:0]  key,
  output logic [IW-1:0]                idx,
  output logic                         done
);

  if ((ENTRIES & (ENTRIES - 1)) == 0) begin : gen_mask
    logic [IW-1:0] idx_r;
    logic          done_r;

    // power of two: the slot is the low bits
    always_ff @(posedge clk) begin
      if (start) begin
        idx_r <= key[IW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        done_r <= 1'b0;
      end else if (start) begin
        done_r <= 1'b1;
      end
    end

    assign idx  = idx_r;
    assign done = done_r;
  end else begin : gen_iter
    localparam logic [IW:0] MODULUS = (IW+1)'(ENTRIES);
    localparam int STEPS = hktc_pkg::HASH_W / hktc_pkg::MOD_BITS;
    localparam int CW = $clog2(STEPS);

    logic [hktc_pkg::HASH_W-1:0] shreg;
    logic [IW-1:0]               rem;
    logic [IW-1:0]               rem_next;
    logic [CW-1:0]               cnt;
    logic                        running;
    logic                        done_r;

    // restoring remainder, a few key bits per cycle from the msb
    always_comb begin
      logic [IW:0]   t;
      logic [IW-1:0] r;
      r = rem;
      for (int k = 0; k < hktc_pkg::MOD_BITS; k++) begin
        t = {r, shreg[hktc_pkg::HASH_W-1-k]};
        if (t >= MODULUS) begin
          t = t - MODULUS;
        end
        r = t[IW-1:0];
      end
      rem_next = r;
    end

    // operand and partial remainder
    always_ff @(posedge clk) begin
      if (start) begin
        shreg <= key;
        rem   <= '0;
      end else if (running) begin
        shreg <= shreg << hktc_pkg::MOD_BITS;
        rem   <= rem_next;
      end
    end

    // step counter and completion
    always_ff @(posedge clk) begin
      if (rst) begin
        running <= 1'b0;
        done_r  <= 1'b0;
        cnt     <= '0;
      end else if (start) begin
        running <= 1'b1;
        done_r  <= 1'b0;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(STEPS - 1)) begin
          running <= 1'b0;
          done_r  <= 1'b1;
        end
      end
    end

    assign idx  = rem;
    assign done = done_r;
  end

endmodule

[rtl/hktc_dp.sv]
module hktc_dp #(
  parameter int ENTRIES = 256,
  localparam int IW = $clog2(ENTRIES)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  hktc_pkg::cmd_t                  cmd,
  output hktc_pkg::status_t               status,
  input  logic [hktc_pkg::BYTE_W-1:0]     key_byte,
  input  logic                            final_byte,
  input  logic [hktc_pkg::HASH_W-1:0]     key_hash,
  input  logic [hktc_pkg::WORD_W-1:0]     sigma_value,
  input  logic [hktc_pkg::WORD_W-1:0]     now_seconds,
  input  logic                            cfg_valid,
  input  logic [hktc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hktc_pkg::WORD_W-1:0]     cfg_data,
  output logic                            result_valid,
  output logic                            result_kind,
  output logic [hktc_pkg::HASH_W-1:0]     hash_value,
  output logic                            hit,
  output logic [hktc_pkg::WORD_W-1:0]     cached_sigma
);

  logic                          cache_enable;
  logic [hktc_pkg::WORD_W-1:0]   ttl_seconds;
  logic [hktc_pkg::HASH_W-1:0]   running_hash;
  logic [hktc_pkg::HASH_W-1:0]   hash_next;
  logic [hktc_pkg::BYTE_W-1:0]   byte_r;
  logic                          final_r;
  logic [hktc_pkg::HASH_W-1:0]   key_r;
  logic [hktc_pkg::WORD_W-1:0]   sigma_r;
  logic [hktc_pkg::WORD_W-1:0]   now_r;
  logic [IW-1:0]                 slot;
  logic [IW-1:0]                 clr_cnt;
  logic [IW-1:0]                 mem_addr;
  logic                          mem_we;
  hktc_pkg::entry_t              mem_wdata;
  hktc_pkg::entry_t              rd_entry;
  hktc_pkg::entry_t              mem [ENTRIES];
  logic [hktc_pkg::WORD_W-1:0]   elapsed;
  logic                          lookup_hit;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cache_enable <= 1'b1;
      ttl_seconds  <= hktc_pkg::TTL_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        hktc_pkg::REG_CACHE_ENABLE: cache_enable <= cfg_data[0];
        hktc_pkg::REG_TTL_SECONDS:  ttl_seconds  <= cfg_data;
        default: ;
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      byte_r  <= key_byte;
      final_r <= final_byte;
      key_r   <= key_hash;
      sigma_r <= sigma_value;
      now_r   <= now_seconds;
    end
  end

  // running fnv-1a hash
  assign hash_next = hktc_pkg::fnv_step(running_hash, byte_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= hktc_pkg::FNV_BASIS;
    end else if (cmd.hash_step) begin
      running_hash <= final_r ? hktc_pkg::FNV_BASIS : hash_next;
    end
  end

  // slot index from the key hash
  hktc_mod #(.ENTRIES(ENTRIES)) u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mod_start),
    .key   (key_hash),
    .idx   (slot),
    .done  (status.mod_done)
  );

  // clearing pass pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_step) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  assign status.clear_last = (clr_cnt == IW'(ENTRIES - 1));

  // table port
  assign mem_addr = cmd.clear_step ? clr_cnt : slot;
  assign mem_we   = cmd.clear_step || (cmd.mem_write && cache_enable);

  always_comb begin
    if (cmd.clear_step) begin
      mem_wdata = '0;
    end else begin
      mem_wdata.valid = 1'b1;
      mem_wdata.tag   = key_r;
      mem_wdata.sigma = sigma_r;
      mem_wdata.stamp = now_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (cmd.mem_read) begin
      rd_entry <= mem[mem_addr];
    end
  end

  // hit check
  assign elapsed    = now_r - rd_entry.stamp;
  assign lookup_hit = cache_enable && rd_entry.valid && (rd_entry.tag == key_r) &&
                      (elapsed < ttl_seconds);

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (cmd.hash_step && final_r) || cmd.check;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.hash_step && final_r) begin
      result_kind  <= hktc_pkg::RESULT_HASH;
      hash_value   <= hash_next;
      hit          <= 1'b0;
      cached_sigma <= '0;
    end else if (cmd.check) begin
      result_kind  <= hktc_pkg::RESULT_LOOKUP;
      hash_value   <= '0;
      hit          <= lookup_hit;
      cached_sigma <= lookup_hit ? rd_entry.sigma : hktc_pkg::MISS_SCORE;
    end
  end

endmodule

[rtl/hktc_ctrl.sv]
`include "hashed_key_ttl_cache_defines.svh"

module hktc_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [hktc_pkg::OP_W-1:0]   operation,
  output logic                        busy,
  output hktc_pkg::cmd_t              cmd,
  input  hktc_pkg::status_t           status
);

  typedef enum logic [5:0] {
    S_CLEAR    = 6'b000001,
    S_IDLE     = 6'b000010,
    S_HASH     = 6'b000100,
    S_LK_INDEX = 6'b001000,
    S_LK_READ  = 6'b010000,
    S_ST_INDEX = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.capture = accept;
        if (accept) begin
          case (operation)
            hktc_pkg::OP_HASH: begin
              state_next = S_HASH;
            end
            hktc_pkg::OP_LOOKUP: begin
              cmd.mod_start = 1'b1;
              state_next    = S_LK_INDEX;
            end
            hktc_pkg::OP_STORE: begin
              cmd.mod_start = 1'b1;
              state_next    = S_ST_INDEX;
            end
            default: ;
          endcase
        end
      end
      S_HASH: begin
        cmd.hash_step = 1'b1;
        state_next    = S_IDLE;
      end
      S_LK_INDEX: begin
        if (status.mod_done) begin
          cmd.mem_read = 1'b1;
          state_next   = S_LK_READ;
        end
      end
      S_LK_READ: begin
        cmd.check  = 1'b1;
        state_next = S_IDLE;
      end
      S_ST_INDEX: begin
        if (status.mod_done) begin
          cmd.mem_write = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // the hit check always follows a table read
  `HKTC_ASSERT(a_check_after_read, clk, rst, (state == S_LK_READ) |-> $past(cmd.mem_read))
  // the clearing pass hands over to idle once the last entry is written
  `HKTC_ASSERT(a_clear_ends, clk, rst, ((state == S_CLEAR) && status.clear_last) |=> (state == S_IDLE))
  // an index state holds until the slot is ready
  `HKTC_ASSERT(a_index_waits, clk, rst, (((state == S_LK_INDEX) || (state == S_ST_INDEX)) && !status.mod_done) |=> (state == $past(state)))

endmodule

[rtl/hashed_key_ttl_cache.sv]
// channel    | signals                                             | handshake
// -----------+-----------------------------------------------------+---------------------------
// request    | operation key_byte final_byte key_hash              | start && !busy
//            | sigma_value now_seconds                             |
// result     | result_kind hash_value hit cached_sigma             | result_valid, one cycle
// config     | cfg_index cfg_data                                  | cfg_valid && cfg_ready
//
// a hash byte passes capture and fold; a store capture and table write; a lookup capture,
// table read and hit check on the registered entry; the table has a single port
// when ENTRIES is not a power of two the slot index comes from a remainder unit taking
// 4 key bits a cycle, which each lookup and store waits on in its index state
// after reset the table is cleared one entry a cycle, with busy high until the last entry;
// configuration writes are taken throughout
// results are strobed for one cycle and cannot be held off by the receiver
module hashed_key_ttl_cache #(
  parameter int ENTRIES = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [hktc_pkg::OP_W-1:0]       operation,
  input  logic [hktc_pkg::BYTE_W-1:0]     key_byte,
  input  logic                            final_byte,
  input  logic [hktc_pkg::HASH_W-1:0]     key_hash,
  input  logic [hktc_pkg::WORD_W-1:0]     sigma_value,
  input  logic [hktc_pkg::WORD_W-1:0]     now_seconds,
  output logic                            result_valid,
  output logic                            result_kind,
  output logic [hktc_pkg::HASH_W-1:0]     hash_value,
  output logic                            hit,
  output logic [hktc_pkg::WORD_W-1:0]     cached_sigma,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hktc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hktc_pkg::WORD_W-1:0]     cfg_data
);

  hktc_pkg::cmd_t    cmd;
  hktc_pkg::status_t status;

  // configuration writes never stall
  assign cfg_ready = 1'b1;

  // controller
  hktc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .busy      (busy),
    .cmd       (cmd),
    .status    (status)
  );

  // datapath
  hktc_dp #(.ENTRIES(ENTRIES)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .key_byte     (key_byte),
    .final_byte   (final_byte),
    .key_hash     (key_hash),
    .sigma_value  (sigma_value),
    .now_seconds  (now_seconds),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result_kind  (result_kind),
    .hash_value   (hash_value),
    .hit          (hit),
    .cached_sigma (cached_sigma)
  );

endmodule

[sim/hktc_result_check.sv]
module hktc_result_check #(
  parameter int ENTRIES = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            busy,
  input  logic [hktc_pkg::OP_W-1:0]       operation,
  input  logic [hktc_pkg::BYTE_W-1:0]     key_byte,
  input  logic                            final_byte,
  input  logic [hktc_pkg::HASH_W-1:0]     key_hash,
  input  logic [hktc_pkg::WORD_W-1:0]     sigma_value,
  input  logic [hktc_pkg::WORD_W-1:0]     now_seconds,
  input  logic                            result_valid,
  input  logic                            result_kind,
  input  logic [hktc_pkg::HASH_W-1:0]     hash_value,
  input  logic                            hit,
  input  logic [hktc_pkg::WORD_W-1:0]     cached_sigma,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [hktc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hktc_pkg::WORD_W-1:0]     cfg_data,
  output int                              fail_count,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import hktc_pkg::*;

  localparam logic [HASH_W-1:0] FNV_PRIME_64 = 64'h0000_0100_0000_01b3;

  typedef struct packed {
    logic              kind;
    logic [HASH_W-1:0] hash;
    logic              hit;
    logic [WORD_W-1:0] sigma;
  } cache_result_t;

  // results still owed by the block, oldest first
  cache_result_t     owed_results[$];
  int                errors;

  // shadow of the block state and registers
  logic [HASH_W-1:0] fold_hash;
  logic              enable_q;
  logic [WORD_W-1:0] ttl_q;
  logic              slot_live  [ENTRIES];
  logic [HASH_W-1:0] slot_tag   [ENTRIES];
  logic [WORD_W-1:0] slot_score [ENTRIES];
  logic [WORD_W-1:0] slot_stamp [ENTRIES];

  // apply one accepted request to the shadow state, queue its result if any
  task automatic apply_request(input logic [OP_W-1:0]   op,
                               input logic [BYTE_W-1:0] kb,
                               input logic              last,
                               input logic [HASH_W-1:0] khash,
                               input logic [WORD_W-1:0] score,
                               input logic [WORD_W-1:0] now);
    int unsigned   idx;
    logic [WORD_W-1:0] elapsed;
    cache_result_t r;
    idx = int'(khash % 64'(ENTRIES));
    case (op)
      OP_HASH: begin
        fold_hash = (fold_hash ^ {{(HASH_W-BYTE_W){1'b0}}, kb}) * FNV_PRIME_64;
        if (last) begin
          r.kind  = RESULT_HASH;
          r.hash  = fold_hash;
          r.hit   = 1'b0;
          r.sigma = '0;
          owed_results.push_back(r);
          fold_hash = FNV_BASIS;
        end
      end
      OP_LOOKUP: begin
        elapsed = now - slot_stamp[idx];
        r.kind  = RESULT_LOOKUP;
        r.hash  = '0;
        r.hit   = enable_q && slot_live[idx] && (slot_tag[idx] == khash) && (elapsed < ttl_q);
        r.sigma = r.hit ? slot_score[idx] : MISS_SCORE;
        owed_results.push_back(r);
      end
      OP_STORE: begin
        if (enable_q) begin
          slot_live[idx]  = 1'b1;
          slot_tag[idx]   = khash;
          slot_score[idx] = score;
          slot_stamp[idx] = now;
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    cache_result_t want;
    if (rst) begin
      fold_hash = FNV_BASIS;
      enable_q  = 1'b1;
      ttl_q     = TTL_RESET;
      for (int i = 0; i < ENTRIES; i++) begin
        slot_live[i]  = 1'b0;
        slot_tag[i]   = '0;
        slot_score[i] = '0;
        slot_stamp[i] = '0;
      end
      owed_results.delete();
      errors = 0;
      fail_count <= 0;
      pending    <= 0;
    end else begin
      // compare a strobed result against the oldest owed one
      if (result_valid) begin
        if (owed_results.size() == 0) begin
          $error("result with no request waiting for it");
          errors++;
        end else begin
          want = owed_results.pop_front();
          if (result_kind !== want.kind) begin
            $error("result_kind: expected %0d, got %0d", want.kind, result_kind);
            errors++;
          end
          if (hash_value !== want.hash) begin
            $error("hash_value: expected %h, got %h", want.hash, hash_value);
            errors++;
          end
          if (hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, hit);
            errors++;
          end
          if (cached_sigma !== want.sigma) begin
            $error("cached_sigma: expected %h, got %h", want.sigma, cached_sigma);
            errors++;
          end
        end
      end
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CACHE_ENABLE: enable_q = cfg_data[0];
          REG_TTL_SECONDS:  ttl_q = cfg_data;
          default: begin
          end
        endcase
      end
      // accepted request
      if (start && !busy) begin
        apply_request(operation, key_byte, final_byte, key_hash, sigma_value, now_seconds);
      end
      pending    <= owed_results.size();
      fail_count <= errors;
    end
  end

endmodule

[sim/hashed_key_ttl_cache_test.sv]
module hashed_key_ttl_cache_test;
  timeunit 1ns;
  timeprecision 1ps;
  import hktc_pkg::*;

  localparam int ENTRIES = 256;
  localparam logic [OP_W-1:0]      OP_UNUSED  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd2;
  localparam int DRAIN_CYCLES     = 8;
  localparam int STALL_LIMIT      = 3000;
  localparam int RANDOM_PER_PHASE = 145;
  localparam int KEY_HISTORY      = 64;

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 start        = 1'b0;
  logic                 busy;
  logic [OP_W-1:0]      operation    = '0;
  logic [BYTE_W-1:0]    key_byte     = '0;
  logic                 final_byte   = 1'b0;
  logic [HASH_W-1:0]    key_hash     = '0;
  logic [WORD_W-1:0]    sigma_value  = '0;
  logic [WORD_W-1:0]    now_seconds  = '0;
  logic                 result_valid;
  logic                 result_kind;
  logic [HASH_W-1:0]    hash_value;
  logic                 hit;
  logic [WORD_W-1:0]    cached_sigma;
  logic                 cfg_valid    = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [WORD_W-1:0]    cfg_data     = '0;
  int                   fail_count;
  int                   pending;

  // keys known to sit in a written slot, used to aim lookups and refresh stores
  typedef struct {
    logic [HASH_W-1:0] key;
    logic [WORD_W-1:0] stamp;
  } stored_key_t;

  stored_key_t       stored_keys[$];
  int                sender_idle_pct = 0;
  logic              en_now  = 1'b1;
  logic [WORD_W-1:0] ttl_now = TTL_RESET;
  logic [WORD_W-1:0] wall    = '0;
  int                stall_cycles = 0;

  hashed_key_ttl_cache #(.ENTRIES(ENTRIES)) u_dut (.*);

  hktc_result_check #(.ENTRIES(ENTRIES)) u_check (.*);

  always #4 clk = ~clk;

  // watchdog on cycles with no handshake of any kind
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // one request, with a random gap in front of it
  task automatic send(input logic [OP_W-1:0]   op,
                      input logic [BYTE_W-1:0] kb,
                      input logic              last,
                      input logic [HASH_W-1:0] kh,
                      input logic [WORD_W-1:0] score,
                      input logic [WORD_W-1:0] now);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    operation   <= op;
    key_byte    <= kb;
    final_byte  <= last;
    key_hash    <= kh;
    sigma_value <= score;
    now_seconds <= now;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (op == OP_STORE && en_now) begin
      stored_keys.push_back('{kh, now});
      if (stored_keys.size() > KEY_HISTORY) void'(stored_keys.pop_front());
    end
  endtask

  // register write; the caller drops cfg_valid after the last one
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_CACHE_ENABLE: en_now = data[0];
      REG_TTL_SECONDS:  ttl_now = data;
      default: begin
      end
    endcase
  endtask

  // let the block finish everything in flight
  task automatic settle();
    start <= 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
  endtask

  // lookup aimed at a written slot, elapsed time placed around the ttl
  task automatic random_lookup();
    stored_key_t       pick;
    logic [HASH_W-1:0] kh;
    logic [WORD_W-1:0] elapsed;
    pick = stored_keys[$urandom_range(stored_keys.size() - 1)];
    kh   = pick.key;
    // same slot, different tag
    if ($urandom_range(9) == 0) begin
      kh = {$urandom(), $urandom()};
      kh[7:0] = pick.key[7:0];
    end
    case ($urandom_range(5))
      0: elapsed = '0;
      1: elapsed = ttl_now - 1;
      2: elapsed = ttl_now;
      3: elapsed = ttl_now + 1;
      4: elapsed = (ttl_now > 1) ? $urandom_range(ttl_now - 1) : '0;
      default: elapsed = $urandom();
    endcase
    send(OP_LOOKUP, 8'($urandom()), 1'($urandom()), kh, $urandom(), pick.stamp + elapsed);
  endtask

  // store of a fresh key or a refresh of a known one
  task automatic random_store();
    logic [HASH_W-1:0] kh;
    logic [WORD_W-1:0] now;
    if ($urandom_range(1) == 0 || stored_keys.size() == 0) begin
      kh = {$urandom(), $urandom()};
    end else begin
      kh = stored_keys[$urandom_range(stored_keys.size() - 1)].key;
    end
    now = ($urandom_range(1) == 0) ? wall : $urandom();
    send(OP_STORE, 8'($urandom()), 1'($urandom()), kh, $urandom(), now);
  endtask

  initial begin
    int served;
    int roll;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // registers are taken during the clearing pass
    write_reg(REG_CACHE_ENABLE, 32'd1);
    write_reg(REG_TTL_SECONDS, 32'd100);
    cfg_valid <= 1'b0;
    sender_idle_pct = 29;

    // hashing, with an unused code in the middle of a key
    send(OP_HASH, 8'h00, 1'b0, '1, '1, '1);
    send(OP_UNUSED, 8'hFF, 1'b1, '1, '1, '1);
    send(OP_HASH, 8'hFF, 1'b1, '0, '0, '0);
    send(OP_HASH, 8'h80, 1'b1, '1, '0, '1);
    // store at time zero, hit just inside the ttl, miss at the ttl
    send(OP_STORE, 8'h00, 1'b0, '0, '0, '0);
    send(OP_LOOKUP, 8'h00, 1'b0, '0, '1, 32'd99);
    send(OP_LOOKUP, 8'h00, 1'b0, '0, '1, 32'd100);
    // time wrap in both directions
    send(OP_STORE, 8'hFF, 1'b1, '1, '1, 32'hFFFF_FFF0);
    send(OP_LOOKUP, 8'hFF, 1'b1, '1, '0, 32'd5);
    send(OP_LOOKUP, 8'hFF, 1'b1, '1, '0, 32'hFFFF_FFEF);
    // tag mismatch in a live slot
    send(OP_LOOKUP, 8'h00, 1'b0, 64'h100, '0, 32'd1);
    // zero ttl
    settle();
    write_reg(REG_TTL_SECONDS, 32'd0);
    cfg_valid <= 1'b0;
    send(OP_LOOKUP, 8'h00, 1'b0, '0, '0, 32'd0);
    // disabled cache ignores the store and misses
    settle();
    write_reg(REG_CACHE_ENABLE, 32'd0);
    write_reg(REG_TTL_SECONDS, 32'hFFFF_FFFF);
    cfg_valid <= 1'b0;
    send(OP_STORE, 8'h00, 1'b0, '0, 32'h1234_5678, 32'd0);
    send(OP_LOOKUP, 8'h00, 1'b0, '0, '0, 32'd1);
    // enabled again, the old entry is still there
    settle();
    write_reg(REG_CACHE_ENABLE, 32'd1);
    cfg_valid <= 1'b0;
    send(OP_LOOKUP, 8'h00, 1'b0, '0, '0, 32'd1);

    // random phases, each with its own register writes; pacing is shared by pairs of phases
    for (int phase = 0; phase < 6; phase++) begin
      settle();
      case (phase)
        0: begin
          sender_idle_pct = 29;
          write_reg(REG_CACHE_ENABLE, 32'd1);
          write_reg(REG_TTL_SECONDS, $urandom_range(5000, 10));
        end
        1: begin
          sender_idle_pct = 29;
          write_reg(REG_TTL_SECONDS, 32'hFFFF_FFFF);
        end
        2: begin
          sender_idle_pct = 88;
          write_reg(REG_TTL_SECONDS, 32'd1);
        end
        3: begin
          sender_idle_pct = 88;
          write_reg(REG_CACHE_ENABLE, {31'($urandom_range(32'h7FFF_FFFF)), 1'b0});
          write_reg(REG_TTL_SECONDS, $urandom_range(5000, 10));
        end
        4: begin
          sender_idle_pct = 0;
          write_reg(REG_CACHE_ENABLE, {31'($urandom_range(32'h7FFF_FFFF)), 1'b1});
          write_reg(REG_TTL_SECONDS, 32'd0);
        end
        default: begin
          sender_idle_pct = 0;
          write_reg(REG_UNUSED, $urandom());
          write_reg(REG_TTL_SECONDS, $urandom());
        end
      endcase
      cfg_valid <= 1'b0;
      wall = $urandom();

      served = 0;
      while (served < RANDOM_PER_PHASE) begin
        roll = $urandom_range(99);
        if (roll < 40) begin
          send(OP_HASH, 8'($urandom()), ($urandom_range(3) == 0), {$urandom(), $urandom()},
               $urandom(), $urandom());
        end else if (roll < 70) begin
          random_lookup();
        end else if (roll < 92) begin
          random_store();
        end else begin
          send(OP_UNUSED, 8'($urandom()), 1'($urandom()), {$urandom(), $urandom()},
               $urandom(), $urandom());
        end
        if (roll < 92) served++;
        wall = wall + $urandom_range(3);
      end
    end

    // drain and report
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/hktc_pkg.sv
rtl/hktc_mod.sv
rtl/hktc_dp.sv
rtl/hktc_ctrl.sv
rtl/hashed_key_ttl_cache.sv
sim/hktc_result_check.sv
sim/hashed_key_ttl_cache_test.sv
